// File: rtl/core/hrlc_pkg.sv
package hrlc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned TailW    = 24;
  localparam int unsigned CountW   = 3;
  localparam int unsigned PosW     = 4;
  localparam int unsigned VerdictW = 2;

  typedef enum logic [VerdictW-1:0] {
    VerdictOk      = 2'd0,
    VerdictBad     = 2'd1,
    VerdictNotImpl = 2'd2
  } verdict_e;

  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChSlash = 8'h2F;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChOne   = 8'h31;
  localparam logic [ByteW-1:0] ChNul   = 8'h00;

  // "/.." as the last three bytes of a word
  localparam logic [TailW-1:0] TailDotdot = 24'h2F2E2E;

  localparam logic [CountW-1:0] WordMethod  = 3'd1;
  localparam logic [CountW-1:0] WordPath    = 3'd2;
  localparam logic [CountW-1:0] WordVersion = 3'd3;
  localparam logic [CountW-1:0] CountMax    = 3'd7;
  localparam logic [PosW-1:0]   PosMax      = 4'd15;
  localparam logic [PosW-1:0]   MethodLen   = 4'd3;
  localparam logic [PosW-1:0]   VersionMinor = 4'd7;
  localparam logic [PosW-1:0]   VersionLen  = 4'd8;

  function automatic logic is_sep(input logic [ByteW-1:0] b);
    return (b == ChTab) || (b == ChSpace) || (b == ChCr) || (b == ChLf);
  endfunction

  // "GET"
  function automatic logic [ByteW-1:0] method_char(input logic [1:0] pos);
    logic [ByteW-1:0] c;
    case (pos)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "HTTP/1."
  function automatic logic [ByteW-1:0] version_char(input logic [2:0] pos);
    logic [ByteW-1:0] c;
    case (pos)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2F;
      3'd5:    c = 8'h31;
      3'd6:    c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/http_request_line_check.sv
// The verdict is registered when the tlast beat steps out of the input register.
// Throughput: one byte per cycle; the only stall is a pending verdict the sink
// has not yet taken while the next line end waits in the input register.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// line parser to its start-of-line state.
module http_request_line_check (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [hrlc_pkg::ByteW-1:0]  s_axis_tdata_i,   // [7:0] line_byte
  input  logic                        s_axis_tlast_i,   // line_end
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [7:0]                  m_axis_tdata_o    // [1:0] verdict, [7:2] zero
);
  import hrlc_pkg::*;

  // input register
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;

  // parser state
  logic [CountW-1:0] count_q, count_d;
  logic              inword_q, inword_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              meth_ok_q, meth_ok_d;
  logic              ver_ok_q, ver_ok_d;
  logic              slash_q, slash_d;
  logic              dotdot_q, dotdot_d;
  logic [TailW-1:0]  tail_q, tail_d;
  logic              stop_q, stop_d;

  // result register
  logic              out_valid_q, out_valid_d;
  verdict_e          verdict_q, verdict_d;

  logic out_free, step, sep_taken;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || step;
  assign in_valid_d      = s_axis_tready_o ? s_axis_tvalid_i : in_valid_q;

  always_comb begin
    count_d   = count_q;
    inword_d  = inword_q;
    pos_d     = pos_q;
    meth_ok_d = meth_ok_q;
    ver_ok_d  = ver_ok_q;
    slash_d   = slash_q;
    dotdot_d  = dotdot_q;
    tail_d    = tail_q;
    stop_d    = stop_q;
    sep_taken = 1'b0;
    verdict_d = verdict_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;

    if (step) begin
      if (!stop_q) begin
        if (in_byte_q == ChNul) begin
          stop_d = 1'b1;
        end else if (is_sep(in_byte_q)) begin
          sep_taken = 1'b1;
        end else begin
          if (!inword_q) begin
            inword_d = 1'b1;
            pos_d    = '0;
            tail_d   = '0;
            if (count_q != CountMax) count_d = count_q + 3'd1;
          end
          if (count_d == WordMethod) begin
            if (pos_d >= MethodLen || method_char(pos_d[1:0]) != in_byte_q) begin
              meth_ok_d = 1'b0;
            end
          end else if (count_d == WordPath) begin
            if (pos_d == '0 && in_byte_q == ChSlash) slash_d = 1'b1;
            if (tail_d == TailDotdot && in_byte_q == ChSlash) dotdot_d = 1'b1;
          end else if (count_d == WordVersion) begin
            if (pos_d < VersionMinor) begin
              if (version_char(pos_d[2:0]) != in_byte_q) ver_ok_d = 1'b0;
            end else if (pos_d == VersionMinor) begin
              if (in_byte_q != ChZero && in_byte_q != ChOne) ver_ok_d = 1'b0;
            end else begin
              ver_ok_d = 1'b0;
            end
          end
          tail_d = {tail_d[TailW-ByteW-1:0], in_byte_q};
          if (pos_d != PosMax) pos_d = pos_d + 4'd1;
        end
      end

      // close the open word on a separator or at the line end
      if ((sep_taken || in_last_q) && inword_d) begin
        inword_d = 1'b0;
        if (count_d == WordMethod) begin
          if (pos_d != MethodLen) meth_ok_d = 1'b0;
        end else if (count_d == WordPath) begin
          if (tail_d == TailDotdot) dotdot_d = 1'b1;
        end else if (count_d == WordVersion) begin
          if (pos_d != VersionLen) ver_ok_d = 1'b0;
        end
      end

      if (in_last_q) begin
        out_valid_d = 1'b1;
        if (count_d != WordVersion)        verdict_d = VerdictBad;
        else if (!meth_ok_d || !ver_ok_d)  verdict_d = VerdictNotImpl;
        else if (!slash_d || dotdot_d)     verdict_d = VerdictBad;
        else                               verdict_d = VerdictOk;
        // start over for the next line
        count_d   = '0;
        inword_d  = 1'b0;
        pos_d     = '0;
        meth_ok_d = 1'b1;
        ver_ok_d  = 1'b1;
        slash_d   = 1'b0;
        dotdot_d  = 1'b0;
        tail_d    = '0;
        stop_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      inword_q    <= 1'b0;
      pos_q       <= '0;
      meth_ok_q   <= 1'b1;
      ver_ok_q    <= 1'b1;
      slash_q     <= 1'b0;
      dotdot_q    <= 1'b0;
      tail_q      <= '0;
      stop_q      <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      inword_q    <= inword_d;
      pos_q       <= pos_d;
      meth_ok_q   <= meth_ok_d;
      ver_ok_q    <= ver_ok_d;
      slash_q     <= slash_d;
      dotdot_q    <= dotdot_d;
      tail_q      <= tail_d;
      stop_q      <= stop_d;
    end
  end

  // payload registers: load the beat on accept, hold the verdict until taken
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    verdict_q <= verdict_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, verdict_q};

endmodule
